FILE: rtl/core/arp_pkg.sv
// ---------------------------------------------------------------------------
// arp_pkg
// Shared types, codes and the request frame builder of the ARP resolver.
// ---------------------------------------------------------------------------
package arp_pkg;

    localparam int unsigned FRAME_LEN   = 42;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] RETRY_RESET  = 8'd30;
    localparam logic [7:0] BCAST_BYTE   = 8'hFF;
    localparam logic [7:0] ETYPE_HI     = 8'h08;
    localparam logic [7:0] ETYPE_LO     = 8'h06;
    localparam logic [7:0] OPER_HI      = 8'h00;
    localparam logic [7:0] OPER_REPLY   = 8'h02;
    localparam logic [7:0] POS_MAX      = 8'hFF;

    localparam logic [7:0] POS_ETYPE_HI = 8'd12;
    localparam logic [7:0] POS_ETYPE_LO = 8'd13;
    localparam logic [7:0] POS_OPER_HI  = 8'd20;
    localparam logic [7:0] POS_OPER_LO  = 8'd21;
    localparam logic [7:0] POS_SHA      = 8'd22;
    localparam logic [7:0] POS_SPA      = 8'd28;
    localparam logic [7:0] POS_TPA_END  = 8'd32;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_TIMEOUT = 1'b1;

    // arp header from the ethertype on: ethertype, htype, ptype, hlen, plen, oper request
    localparam logic [7:0] HDR [10] = '{8'h08, 8'h06, 8'h00, 8'h01, 8'h08,
                                        8'h00, 8'h06, 8'h04, 8'h00, 8'h01};

    typedef enum logic [1:0] {
        CMD_RESOLVE = 2'd0,
        CMD_RX_BYTE = 2'd1,
        CMD_TICK    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_OWN_MAC     = 2'd0,
        REG_OWN_IP      = 2'd1,
        REG_GW_IP       = 2'd2,
        REG_RETRY_LIMIT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic [31:0] gw_ip;
        logic [7:0]  retry_limit;
    } t_cfg;

    typedef struct packed {
        logic        is_frame;
        logic        status;
        logic [47:0] payload;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] frame_byte(input logic [5:0] i, input t_cfg cfg,
                                              input logic [31:0] tip);
        logic [5:0] k;
        logic [7:0] b;
        k = '0;
        b = '0;
        if (i < 6'd6) begin
            b = BCAST_BYTE;
        end else if (i < 6'd12) begin
            k = 6'd11 - i;
            b = cfg.own_mac[{k[2:0], 3'b000} +: 8];
        end else if (i < 6'd22) begin
            b = HDR[4'(i - 6'd12)];
        end else if (i < 6'd28) begin
            k = 6'd27 - i;
            b = cfg.own_mac[{k[2:0], 3'b000} +: 8];
        end else if (i < 6'd32) begin
            k = 6'd31 - i;
            b = cfg.own_ip[{k[1:0], 3'b000} +: 8];
        end else if (i < 6'd38) begin
            b = '0;
        end else if (i < 6'd42) begin
            k = 6'd41 - i;
            b = tip[{k[1:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/arp_in_if.sv
// ---------------------------------------------------------------------------
// arp_in_if
// Input channel: resolve commands, received frame bytes and poll ticks.
// ---------------------------------------------------------------------------
interface arp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] target_ip;
    logic [7:0]  rx_byte;
    logic        rx_last;

    modport source (output valid, cmd, target_ip, rx_byte, rx_last, input ready);
    modport sink   (input valid, cmd, target_ip, rx_byte, rx_last, output ready);
endinterface

FILE: rtl/core/arp_out_if.sv
// ---------------------------------------------------------------------------
// arp_out_if
// Output channel: transmit frame bytes and resolve completions.
// ---------------------------------------------------------------------------
interface arp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        status;
    logic [47:0] mac;

    modport source (output valid, kind, tx_byte, tx_last, status, mac, input ready);
    modport sink   (input valid, kind, tx_byte, tx_last, status, mac, output ready);
endinterface

FILE: rtl/core/arp_cfg_if.sv
// ---------------------------------------------------------------------------
// arp_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface arp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/arp_front.sv
// ---------------------------------------------------------------------------
// arp_front
// Accepts input items, parses received frames, tracks the pending request
// and its timeout, keeps the gateway cache and queues jobs for the back end.
// ---------------------------------------------------------------------------
module arp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    arp_in_if.sink          i_in,
    input  arp_pkg::t_cfg   i_cfg,
    input  arp_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output arp_pkg::t_job   o_job
);
    import arp_pkg::*;

    logic        r_cache_valid, n_cache_valid;
    logic [47:0] r_cache_mac, n_cache_mac;
    logic        r_waiting, n_waiting;
    logic [31:0] r_pending_ip, n_pending_ip;
    logic [7:0]  r_ticks, n_ticks;
    logic [7:0]  r_rx_pos, n_rx_pos;
    logic        r_rx_hdr_ok, n_rx_hdr_ok;
    logic [47:0] r_rx_mac, n_rx_mac;
    logic [31:0] r_rx_ip, n_rx_ip;
    logic        accept;
    logic [7:0]  p;
    logic [7:0]  b;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign p          = r_rx_pos;
    assign b          = i_in.rx_byte;

    always_comb begin
        n_cache_valid = r_cache_valid;
        n_cache_mac   = r_cache_mac;
        n_waiting     = r_waiting;
        n_pending_ip  = r_pending_ip;
        n_ticks       = r_ticks;
        n_rx_pos      = r_rx_pos;
        n_rx_hdr_ok   = r_rx_hdr_ok;
        n_rx_mac      = r_rx_mac;
        n_rx_ip       = r_rx_ip;
        o_push        = 1'b0;
        o_job         = '0;
        if (accept) begin
            unique case (t_cmd'(i_in.cmd))
                CMD_RESOLVE: begin
                    o_push = 1'b1;
                    if (r_cache_valid && i_in.target_ip == i_cfg.gw_ip) begin
                        o_job.is_frame = 1'b0;
                        o_job.status   = ST_OK;
                        o_job.payload  = r_cache_mac;
                    end else begin
                        o_job.is_frame = 1'b1;
                        o_job.payload  = {16'h0000, i_in.target_ip};
                        n_waiting      = 1'b1;
                        n_pending_ip   = i_in.target_ip;
                        n_ticks        = '0;
                    end
                end
                CMD_RX_BYTE: begin
                    if (p < 8'(FRAME_LEN)) begin
                        if ((p == POS_ETYPE_HI && b != ETYPE_HI)
                                || (p == POS_ETYPE_LO && b != ETYPE_LO)
                                || (p == POS_OPER_HI && b != OPER_HI)
                                || (p == POS_OPER_LO && b != OPER_REPLY)) begin
                            n_rx_hdr_ok = 1'b0;
                        end
                        if (p >= POS_SHA && p < POS_SPA) begin
                            n_rx_mac = {r_rx_mac[39:0], b};
                        end
                        if (p >= POS_SPA && p < POS_TPA_END) begin
                            n_rx_ip = {r_rx_ip[23:0], b};
                        end
                    end
                    if (p != POS_MAX) begin
                        n_rx_pos = p + 8'd1;
                    end
                    if (i_in.rx_last) begin
                        if (r_waiting && n_rx_pos >= 8'(FRAME_LEN) && n_rx_hdr_ok
                                && n_rx_ip == r_pending_ip) begin
                            if (r_pending_ip == i_cfg.gw_ip) begin
                                n_cache_mac   = n_rx_mac;
                                n_cache_valid = 1'b1;
                            end
                            o_push         = 1'b1;
                            o_job.is_frame = 1'b0;
                            o_job.status   = ST_OK;
                            o_job.payload  = n_rx_mac;
                            n_waiting      = 1'b0;
                        end
                        n_rx_pos    = '0;
                        n_rx_hdr_ok = 1'b1;
                        n_rx_mac    = '0;
                        n_rx_ip     = '0;
                    end
                end
                CMD_TICK: begin
                    if (r_waiting) begin
                        if (r_ticks != POS_MAX) begin
                            n_ticks = r_ticks + 8'd1;
                        end
                        if (n_ticks >= i_cfg.retry_limit) begin
                            o_push         = 1'b1;
                            o_job.is_frame = 1'b0;
                            o_job.status   = ST_TIMEOUT;
                            o_job.payload  = '0;
                            n_waiting      = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_valid <= 1'b0;
            r_cache_mac   <= '0;
            r_waiting     <= 1'b0;
            r_pending_ip  <= '0;
            r_ticks       <= '0;
            r_rx_pos      <= '0;
            r_rx_hdr_ok   <= 1'b1;
            r_rx_mac      <= '0;
            r_rx_ip       <= '0;
        end else begin
            r_cache_valid <= n_cache_valid;
            r_cache_mac   <= n_cache_mac;
            r_waiting     <= n_waiting;
            r_pending_ip  <= n_pending_ip;
            r_ticks       <= n_ticks;
            r_rx_pos      <= n_rx_pos;
            r_rx_hdr_ok   <= n_rx_hdr_ok;
            r_rx_mac      <= n_rx_mac;
            r_rx_ip       <= n_rx_ip;
        end
    end

endmodule

FILE: rtl/core/arp_queue.sv
// ---------------------------------------------------------------------------
// arp_queue
// Short job queue between the front end and the transmit back end.
// ---------------------------------------------------------------------------
module arp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  arp_pkg::t_job    i_job,
    input  logic             i_pop,
    output arp_pkg::t_job    o_job,
    output arp_pkg::t_q_stat o_stat
);
    import arp_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/arp_back.sv
// ---------------------------------------------------------------------------
// arp_back
// Takes jobs from the queue and drives the output register: one completion
// item, or the 42 bytes of a broadcast ARP request frame.
// ---------------------------------------------------------------------------
module arp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  arp_pkg::t_cfg    i_cfg,
    input  arp_pkg::t_job    i_job,
    input  arp_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    arp_out_if.source        o_out
);
    import arp_pkg::*;

    logic        r_busy, n_busy;
    logic [5:0]  r_idx, n_idx;
    logic [31:0] r_tip, n_tip;
    logic        r_valid, n_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_tx_byte, n_tx_byte;
    logic        r_tx_last, n_tx_last;
    logic        r_status, n_status;
    logic [47:0] r_mac, n_mac;
    logic        out_free;

    assign out_free = !r_valid || o_out.ready;

    always_comb begin
        n_busy    = r_busy;
        n_idx     = r_idx;
        n_tip     = r_tip;
        n_valid   = r_valid;
        n_kind    = r_kind;
        n_tx_byte = r_tx_byte;
        n_tx_last = r_tx_last;
        n_status  = r_status;
        n_mac     = r_mac;
        o_pop     = 1'b0;
        if (out_free) begin
            n_valid = 1'b0;
            if (r_busy) begin
                n_valid   = 1'b1;
                n_kind    = KIND_TX;
                n_tx_byte = frame_byte(r_idx, i_cfg, r_tip);
                n_tx_last = (r_idx == 6'(FRAME_LEN - 1));
                n_status  = ST_OK;
                n_mac     = '0;
                n_idx     = r_idx + 6'd1;
                if (n_tx_last) begin
                    n_busy = 1'b0;
                end
            end else if (!i_q_stat.empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_job.is_frame) begin
                    // first byte goes out with the pop
                    n_busy    = 1'b1;
                    n_idx     = 6'd1;
                    n_tip     = i_job.payload[31:0];
                    n_kind    = KIND_TX;
                    n_tx_byte = frame_byte(6'd0, i_cfg, i_job.payload[31:0]);
                    n_tx_last = 1'b0;
                    n_status  = ST_OK;
                    n_mac     = '0;
                end else begin
                    n_kind    = KIND_DONE;
                    n_tx_byte = '0;
                    n_tx_last = 1'b0;
                    n_status  = i_job.status;
                    n_mac     = i_job.payload;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tip     <= n_tip;
        r_kind    <= n_kind;
        r_tx_byte <= n_tx_byte;
        r_tx_last <= n_tx_last;
        r_status  <= n_status;
        r_mac     <= n_mac;
    end

    assign o_out.valid   = r_valid;
    assign o_out.kind    = r_kind;
    assign o_out.tx_byte = r_tx_byte;
    assign o_out.tx_last = r_tx_last;
    assign o_out.status  = r_status;
    assign o_out.mac     = r_mac;

endmodule

FILE: rtl/core/arp_request_reply_resolver.sv
// ---------------------------------------------------------------------------
// arp_request_reply_resolver
// ARP resolver for Ethernet and IPv4 with a single-entry gateway MAC cache.
// ---------------------------------------------------------------------------
// The input channel takes one item per cycle (resolve command, received frame
// byte or poll tick) as long as the four-entry job queue between the parser
// and the transmitter has room. Cache hits, matching replies and timeouts
// become a single completion item; a cache miss becomes a 42-byte request
// frame sent one byte per cycle by the transmitter while the output is
// ready, and received bytes and ticks keep flowing in meanwhile. Output is
// registered; a stalled output stalls input only once the queue has filled.
// The configuration port is always ready and takes one write per cycle.
module arp_request_reply_resolver (
    input  logic    i_clk,
    input  logic    i_rst_n,
    arp_in_if.sink  i_in,
    arp_cfg_if.sink i_cfg,
    arp_out_if.source o_out
);
    import arp_pkg::*;

    t_cfg    r_cfg;
    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_mac     <= '0;
            r_cfg.own_ip      <= '0;
            r_cfg.gw_ip       <= '0;
            r_cfg.retry_limit <= RETRY_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_OWN_MAC:     r_cfg.own_mac     <= i_cfg.data;
                REG_OWN_IP:      r_cfg.own_ip      <= i_cfg.data[31:0];
                REG_GW_IP:       r_cfg.gw_ip       <= i_cfg.data[31:0];
                REG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    arp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    arp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    arp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
